// ===== src/vlbp_pkg.sv =====
// ----------------------------------------------------------------------------
// vlbp_pkg
// Shared constants and controller/datapath interface types for the
// variable-length bit packer.
// ----------------------------------------------------------------------------
package vlbp_pkg;

  // field widths
  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned VALUE_BITS     = 32;
  localparam int unsigned CNT_W          = 6;
  localparam int unsigned ACT_W          = 2;
  localparam int unsigned USED_W         = 3;
  localparam int unsigned SIZE_W         = 4;
  localparam int unsigned IN_TDATA_W     = 40;
  localparam int unsigned MAX_FIELD_BITS = 32;

  // largest count taken from one item
  localparam logic [CNT_W-1:0] CNT_LIMIT =
    (MAX_FIELD_BITS < VALUE_BITS) ? CNT_W'(MAX_FIELD_BITS) : CNT_W'(VALUE_BITS);

  localparam logic [BYTE_BITS-1:0] BYTE_MASK = 8'hff;

  // action codes
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture value and saturated count
    logic step;   // place one chunk into the partial byte
    logic flush;  // emit partial byte and clear it
    logic clear;  // drop partial byte
  } vlbp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;     // no bits left to place
    logic byte_done;    // current chunk completes a byte
    logic final_chunk;  // current chunk uses up the remaining count
    logic used_zero;    // partial byte is empty
  } vlbp_sts_t;

endpackage

// ===== src/vlbp_datapath.sv =====
// ----------------------------------------------------------------------------
// vlbp_datapath
// Partial byte, shift register for the value, remaining count and the
// output byte register. Places one chunk per step.
// ----------------------------------------------------------------------------
module vlbp_datapath import vlbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [CNT_W-1:0]      bit_count,
  input  vlbp_cmd_t             cmd,
  output vlbp_sts_t             sts,
  output logic [BYTE_BITS-1:0]  out_byte,
  output logic                  out_last
);

  logic [BYTE_BITS-1:0]  partial;
  logic [USED_W-1:0]     used;
  logic [VALUE_BITS-1:0] data;
  logic [CNT_W-1:0]      cnt;

  logic [SIZE_W-1:0]    room;
  logic [SIZE_W-1:0]    size;
  logic [SIZE_W-1:0]    used_sum;
  logic [BYTE_BITS-1:0] chunk;
  logic [BYTE_BITS-1:0] acc_next;
  logic [CNT_W-1:0]     cnt_left;
  logic [CNT_W-1:0]     sat_count;

  // chunk placement: fill the byte from the top down
  always_comb begin
    room     = SIZE_W'(BYTE_BITS) - SIZE_W'(used);
    size     = (CNT_W'(room) < cnt) ? room : cnt[SIZE_W-1:0];
    chunk    = data[BYTE_BITS-1:0] & (BYTE_MASK >> (SIZE_W'(BYTE_BITS) - size));
    acc_next = partial | (chunk << (room - size));
    used_sum = SIZE_W'(used) + size;
    cnt_left = cnt - CNT_W'(size);
    sat_count = (bit_count > CNT_LIMIT) ? CNT_LIMIT : bit_count;
  end

  assign sts.cnt_zero    = (cnt == '0);
  assign sts.byte_done   = (used_sum == SIZE_W'(BYTE_BITS));
  assign sts.final_chunk = (cnt_left == '0);
  assign sts.used_zero   = (used == '0);

  // partial byte and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      used    <= '0;
    end else if (cmd.flush || cmd.clear) begin
      partial <= '0;
      used    <= '0;
    end else if (cmd.step) begin
      if (used_sum == SIZE_W'(BYTE_BITS)) begin
        partial <= '0;
        used    <= '0;
      end else begin
        partial <= acc_next;
        used    <= used_sum[USED_W-1:0];
      end
    end
  end

  // value shifter and remaining count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data <= value;
      cnt  <= sat_count;
    end else if (cmd.step) begin
      data <= data >> size;
      cnt  <= cnt_left;
    end
  end

  // output byte register
  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      out_byte <= partial;
      out_last <= 1'b1;
    end else if (cmd.step && (used_sum == SIZE_W'(BYTE_BITS))) begin
      out_byte <= acc_next;
      out_last <= (cnt_left < CNT_W'(BYTE_BITS));
    end
  end

endmodule

// ===== src/vlbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// vlbp_ctrl
// Sequencer for the bit packer: takes an item, steps the datapath one chunk
// per cycle (a full output slot stalls it), holds the output byte valid flag.
// ----------------------------------------------------------------------------
module vlbp_ctrl import vlbp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [ACT_W-1:0] s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  output vlbp_cmd_t        cmd,
  input  vlbp_sts_t        sts
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [ACT_W-1:0] op;
  logic             slot_free;
  logic             accept;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.load = accept;
        if (accept) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        unique case (op)
          ACT_WRITE: begin
            if (sts.cnt_zero) begin
              state_next = S_IDLE;
            end else if (!sts.byte_done || slot_free) begin
              cmd.step = 1'b1;
              if (sts.final_chunk) begin
                state_next = S_IDLE;
              end
            end
          end
          ACT_FLUSH: begin
            if (sts.used_zero) begin
              cmd.clear  = 1'b1;
              state_next = S_IDLE;
            end else if (slot_free) begin
              cmd.flush  = 1'b1;
              state_next = S_IDLE;
            end
          end
          ACT_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state, latched action and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      op       <= ACT_WRITE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        op <= s_tuser;
      end
      if (cmd.flush || (cmd.step && sts.byte_done)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // no step, flush or clear while waiting for an item
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.step && !cmd.flush && !cmd.clear)
    else $error("datapath commanded while idle");

  // a byte is loaded only into a free output slot
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush || (cmd.step && sts.byte_done)) |-> (!m_tvalid || m_tready))
    else $error("output byte overwritten");

  // flush emits only a nonempty partial byte
  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> !sts.used_zero)
    else $error("flush of empty partial byte");

  // a new byte is presented after it was loaded
  a_byte_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && sts.byte_done) |=> m_tvalid)
    else $error("completed byte not presented");
`endif

endmodule

// ===== src/variable_length_bit_packer.sv =====
// ----------------------------------------------------------------------------
// variable_length_bit_packer
// Packs fields of 0 to 32 bits into a byte stream, each byte filled from
// bit 7 down; supports flush and clear of the partial byte.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// s_*      in   s_tvalid / s_tready  s_tuser: action; s_tdata: value, bit_count
// m_*      out  m_tvalid / m_tready  m_tdata: out_byte; m_tlast: last
//
// one item is taken per visit to idle: an accept, then one datapath step per
// chunk (a 32-bit write takes four or five chunks), or one flush or clear step
// a completed byte waits in the output register; a full register with
// m_tready low stalls the chunk that would complete the next byte, or a flush
// rst is synchronous and empties the partial byte and the output register
// ----------------------------------------------------------------------------
module variable_length_bit_packer import vlbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,  // value [31:0], bit_count [37:32], zero [39:38]
  input  logic [ACT_W-1:0]      s_tuser,  // action [1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [BYTE_BITS-1:0]  m_tdata,  // out_byte [7:0]
  output logic                  m_tlast
);

  vlbp_cmd_t cmd;
  vlbp_sts_t sts;

  // sequencer
  vlbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // byte assembly
  vlbp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (s_tdata[VALUE_BITS-1:0]),
    .bit_count (s_tdata[VALUE_BITS+CNT_W-1:VALUE_BITS]),
    .cmd       (cmd),
    .sts       (sts),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
